// ----- src/accel_bias_calibrate_deadband_defines.svh -----
// Assertion macros shared by the checker of the bias calibration block.
// Depends on nothing; the including scope provides signals named clock and reset.
`ifndef ACCEL_BIAS_CALIBRATE_DEADBAND_DEFINES_SVH
`define ACCEL_BIAS_CALIBRATE_DEADBAND_DEFINES_SVH

// Checked on every rising edge outside reset.
`define ABCD_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ABCD_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- src/abcd_pkg.sv -----
// Package of the accelerometer bias calibration block: widths, codes, types.
// Used by the channel interfaces, every module and the checker.
`default_nettype none

package abcd_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int SUM_W           = 27;
   localparam int CNT_W           = 11;
   localparam int THR_W           = 15;
   localparam int LEN_W           = 11;
   localparam int MAX_CAL_SAMPLES = 1024;
   localparam int NUM_AXES        = 3;
   localparam int AXIS_W          = 2;
   localparam int FUNC_W          = 2;
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 16;
   localparam int DIV_STEP_W      = $clog2(SAMPLE_W);

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(400);

   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_START  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_BIAS   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_LENGTH = 1'd1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

   typedef struct packed {
      logic       kind;
      sample_type out_x;
      sample_type out_y;
      sample_type out_z;
      logic       cal_valid;
      logic       last;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- src/abcd_channels.sv -----
// Valid/ready channel interfaces of the bias calibration block: request,
// response and register write. Depends on abcd_pkg.
`default_nettype none

interface abcd_req_if import abcd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   sample_type          sample_x;
   sample_type          sample_y;
   sample_type          sample_z;

   modport source (output valid, func, sample_x, sample_y, sample_z, input ready);
   modport sink   (input valid, func, sample_x, sample_y, sample_z, output ready);
endinterface

interface abcd_rsp_if import abcd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       kind;
   sample_type out_x;
   sample_type out_y;
   sample_type out_z;
   logic       cal_valid;
   logic       last;

   modport source (output valid, kind, out_x, out_y, out_z, cal_valid, last,
                   input ready);
   modport sink   (input valid, kind, out_x, out_y, out_z, cal_valid, last,
                   output ready);
endinterface

interface abcd_csr_if import abcd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/abcd_filter.sv -----
// Shared per-axis filter: bias subtraction, saturation and dead-band.
// Combinational, one axis per cycle. Depends on abcd_pkg.
`default_nettype none

module abcd_filter import abcd_pkg::*; (
   input  sample_type       raw,
   input  sample_type       bias,
   input  logic [THR_W-1:0] threshold,
   output sample_type       filt
);

   localparam logic signed [SAMPLE_W+1:0] SAT_HI = (SAMPLE_W+2)'(2**(SAMPLE_W-1) - 1);
   localparam logic signed [SAMPLE_W+1:0] SAT_LO = -SAT_HI - (SAMPLE_W+2)'(1);

   logic signed [SAMPLE_W+1:0] diff;
   sample_type                 sat;
   logic [SAMPLE_W-1:0]        mag;

   always_comb begin
      diff = (SAMPLE_W+2)'(raw) - (SAMPLE_W+2)'(bias);
      priority if (diff > SAT_HI) begin
         sat = SAMPLE_W'(SAT_HI);
      end else if (diff < SAT_LO) begin
         sat = SAMPLE_W'(SAT_LO);
      end else begin
         sat = SAMPLE_W'(diff);
      end
      // The most negative value has a magnitude that still fits unsigned.
      mag  = sat[SAMPLE_W-1] ? SAMPLE_W'(-sat) : SAMPLE_W'(sat);
      filt = (mag < SAMPLE_W'(threshold)) ? '0 : sat;
   end

endmodule

`default_nettype wire

// ----- src/abcd_div.sv -----
// Serial restoring divider for the bias average: signed sum over sample count,
// truncated toward zero, one quotient bit per cycle. Depends on abcd_pkg.
`default_nettype none

module abcd_div import abcd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  sum_type          dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output sample_type       quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [SAMPLE_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]      dvs_ff, dvs_in;
   logic                  neg_ff, neg_in;

   logic [SUM_W-1:0]      abs_full;
   logic [CNT_W:0]        trial;
   logic                  fits;

   always_comb begin
      abs_full = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      trial    = {rem_ff, quo_ff[SAMPLE_W-1]};
      fits     = trial >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;

      if (start) begin
         // The average never exceeds the sample range, so the upper part of the
         // magnitude is already below the divisor and only the low bits need steps.
         busy_in = 1'b1;
         step_in = DIV_STEP_W'(SAMPLE_W - 1);
         rem_in  = CNT_W'(abs_full[SUM_W-2:SAMPLE_W]);
         quo_in  = abs_full[SAMPLE_W-1:0];
         dvs_in  = divisor;
         neg_in  = dividend[SUM_W-1];
      end else if (busy_ff) begin
         rem_in  = fits ? CNT_W'(trial - {1'b0, dvs_ff}) : CNT_W'(trial);
         quo_in  = {quo_ff[SAMPLE_W-2:0], fits};
         step_in = step_ff - DIV_STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? SAMPLE_W'(-quo_ff) : SAMPLE_W'(quo_ff);

endmodule

`default_nettype wire

// ----- src/accel_bias_calibrate_deadband.sv -----
// Accelerometer bias calibration with dead-band: top level.
// Depends on abcd_pkg, the channel interfaces, abcd_filter and abcd_div.
//
// Usage: req_if carries one word per command: a three-axis sample, a start of
// calibration or a clear of the running sums. Each sample word returns one
// filtered word on rsp_if; the sample that closes a calibration window returns
// the filtered word (last low) followed by a bias word (last high).
// csr_if writes the dead-band threshold and the window length; it is always
// ready, and a write takes effect from the next cycle, so it belongs between words.
// Timing: start and clear words complete on acceptance. A sample word runs its three
// axes one per cycle through a shared filter unit; its result is loaded once
// the response register is free, and req_if is ready again in that same cycle
// unless the sample closes a window. Then the shared serial divider computes the
// three biases one after another, 16 steps each, and the bias word is loaded once
// the last bias is in and the register is free; an empty window skips the divider.
// Reset empties the sums, zeroes the bias, stops calibration and drops any
// pending response. A stalled receiver holds the response register; a sample
// may still be taken, and its result waits until the register is free.
`default_nettype none

module accel_bias_calibrate_deadband import abcd_pkg::*; (
   input logic         clock,
   input logic         reset,
   abcd_req_if.sink    req_if,
   abcd_rsp_if.source  rsp_if,
   abcd_csr_if.sink    csr_if
);

   typedef enum logic [4:0] {
      S_IDLE       = 5'b00001,
      S_FILT       = 5'b00010,
      S_SAMPLE_OUT = 5'b00100,
      S_DIV        = 5'b01000,
      S_BIAS_OUT   = 5'b10000
   } state_type;

   localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_CAL_SAMPLES);

   state_type         state_ff, state_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   sample_type        bias_ff [NUM_AXES];
   sample_type        bias_in [NUM_AXES];
   sum_type           sum_ff  [NUM_AXES];
   sum_type           sum_in  [NUM_AXES];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              cal_ff, cal_in;
   logic [LEN_W-1:0]  prog_ff, prog_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;
   logic              div_run_ff, div_run_in;
   logic              rsp_valid_ff, rsp_valid_in;

   sample_type        samp_ff [NUM_AXES];
   sample_type        samp_in [NUM_AXES];
   sample_type        filt_ff [NUM_AXES];
   sample_type        filt_in [NUM_AXES];
   logic              calv_ff, calv_in;
   rsp_word_type      rsp_ff, rsp_in;

   sample_type        filt_val;
   logic              div_start;
   logic              div_done;
   sample_type        div_q;
   logic              req_take;
   logic              out_free;
   logic [LEN_W-1:0]  len_eff;
   logic [LEN_W-1:0]  prog_inc;
   logic              win_end;

   abcd_filter u_filter (
      .raw       (samp_ff[axis_ff]),
      .bias      (bias_ff[axis_ff]),
      .threshold (thr_ff),
      .filt      (filt_val)
   );

   abcd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[axis_ff]),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;

   always_comb begin
      req_take = req_if.valid && (state_ff == S_IDLE);
      out_free = !rsp_valid_ff || rsp_if.ready;
      len_eff  = (len_ff == '0) ? LEN_W'(1) : len_ff;
      prog_inc = prog_ff + LEN_W'(1);
      win_end  = cal_ff && (prog_inc >= len_eff);

      state_in     = state_ff;
      thr_in       = thr_ff;
      len_in       = len_ff;
      bias_in      = bias_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      cal_in       = cal_ff;
      prog_in      = prog_ff;
      axis_in      = axis_ff;
      div_run_in   = div_run_ff;
      rsp_valid_in = rsp_valid_ff;
      samp_in      = samp_ff;
      filt_in      = filt_ff;
      calv_in      = calv_ff;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;

      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_THRESHOLD:  thr_in = csr_if.data[THR_W-1:0];
            CSR_CAL_LENGTH: len_in = csr_if.data[LEN_W-1:0];
         endcase
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               samp_in[0] = req_if.sample_x;
               samp_in[1] = req_if.sample_y;
               samp_in[2] = req_if.sample_z;
               unique case (req_if.func)
                  FUNC_SAMPLE: begin
                     axis_in  = '0;
                     state_in = S_FILT;
                  end
                  FUNC_START: begin
                     for (int a = 0; a < NUM_AXES; a++) begin
                        sum_in[a]  = '0;
                        bias_in[a] = '0;
                     end
                     count_in = '0;
                     cal_in   = 1'b1;
                     prog_in  = '0;
                  end
                  FUNC_CLEAR: begin
                     for (int a = 0; a < NUM_AXES; a++) begin
                        sum_in[a] = '0;
                     end
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FILT: begin
            filt_in[axis_ff] = filt_val;
            // Once the count saturates, further samples are left out of the sums.
            if (count_ff < CNT_MAX) begin
               sum_in[axis_ff] = sum_ff[axis_ff] + SUM_W'(filt_val);
            end
            if (axis_ff == AXIS_LAST) begin
               if (count_ff < CNT_MAX) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = S_SAMPLE_OUT;
            end else begin
               axis_in = axis_ff + AXIS_W'(1);
            end
         end
         S_SAMPLE_OUT: begin
            if (out_free) begin
               rsp_in.kind      = KIND_SAMPLE;
               rsp_in.out_x     = filt_ff[0];
               rsp_in.out_y     = filt_ff[1];
               rsp_in.out_z     = filt_ff[2];
               rsp_in.cal_valid = 1'b0;
               rsp_in.last      = !win_end;
               rsp_valid_in     = 1'b1;
               if (cal_ff) begin
                  prog_in = prog_inc;
               end
               if (win_end) begin
                  cal_in  = 1'b0;
                  prog_in = '0;
                  axis_in = '0;
                  if (count_ff != '0) begin
                     calv_in  = 1'b1;
                     state_in = S_DIV;
                  end else begin
                     calv_in = 1'b0;
                     for (int a = 0; a < NUM_AXES; a++) begin
                        bias_in[a] = '0;
                     end
                     state_in = S_BIAS_OUT;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DIV: begin
            if (!div_run_ff) begin
               div_start  = 1'b1;
               div_run_in = 1'b1;
            end else if (div_done) begin
               bias_in[axis_ff] = div_q;
               div_run_in       = 1'b0;
               if (axis_ff == AXIS_LAST) begin
                  state_in = S_BIAS_OUT;
               end else begin
                  axis_in = axis_ff + AXIS_W'(1);
               end
            end
         end
         S_BIAS_OUT: begin
            if (out_free) begin
               rsp_in.kind      = KIND_BIAS;
               rsp_in.out_x     = bias_ff[0];
               rsp_in.out_y     = bias_ff[1];
               rsp_in.out_z     = bias_ff[2];
               rsp_in.cal_valid = calv_ff;
               rsp_in.last      = 1'b1;
               rsp_valid_in     = 1'b1;
               for (int a = 0; a < NUM_AXES; a++) begin
                  sum_in[a] = '0;
               end
               count_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= '0;
         len_ff       <= LEN_RESET;
         for (int a = 0; a < NUM_AXES; a++) begin
            bias_ff[a] <= '0;
            sum_ff[a]  <= '0;
         end
         count_ff     <= '0;
         cal_ff       <= 1'b0;
         prog_ff      <= '0;
         axis_ff      <= '0;
         div_run_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         len_ff       <= len_in;
         bias_ff      <= bias_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         cal_ff       <= cal_in;
         prog_ff      <= prog_in;
         axis_ff      <= axis_in;
         div_run_ff   <= div_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_ff <= samp_in;
      filt_ff <= filt_in;
      calv_ff <= calv_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.kind      = rsp_ff.kind;
   assign rsp_if.out_x     = rsp_ff.out_x;
   assign rsp_if.out_y     = rsp_ff.out_y;
   assign rsp_if.out_z     = rsp_ff.out_z;
   assign rsp_if.cal_valid = rsp_ff.cal_valid;
   assign rsp_if.last      = rsp_ff.last;

endmodule

`default_nettype wire

// ----- src/abcd_checker.sv -----
// Port-level checker for the bias calibration block, bound to the top level.
// Depends on abcd_pkg and accel_bias_calibrate_deadband_defines.svh.
`default_nettype none
`include "accel_bias_calibrate_deadband_defines.svh"

module abcd_checker import abcd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [FUNC_W-1:0] req_func,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_kind,
   input sample_type        rsp_out_x,
   input sample_type        rsp_out_y,
   input sample_type        rsp_out_z,
   input logic              rsp_cal_valid,
   input logic              rsp_last
);

   // No response word survives a reset.
   `ABCD_CHECK_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "response valid after reset")

   // A stalled response word keeps its contents.
   `ABCD_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_kind, rsp_out_x, rsp_out_y, rsp_out_z, rsp_cal_valid, rsp_last}), "stalled response changed")

   // A sample word keeps the block busy while its axes are filtered.
   `ABCD_CHECK(a_sample_busy, req_valid && req_ready && req_func == FUNC_SAMPLE |=> !req_ready, "ready right after a sample")

   // The bias word always closes the results of its sample.
   `ABCD_CHECK(a_bias_last, rsp_valid && rsp_kind == KIND_BIAS |-> rsp_last, "bias word without last")

   // An empty window reports a zero bias.
   `ABCD_CHECK(a_empty_zero, rsp_valid && rsp_kind == KIND_BIAS && !rsp_cal_valid |-> rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0, "empty window with nonzero bias")

endmodule

bind accel_bias_calibrate_deadband abcd_checker u_abcd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .req_func      (req_if.func),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_kind      (rsp_if.kind),
   .rsp_out_x     (rsp_if.out_x),
   .rsp_out_y     (rsp_if.out_y),
   .rsp_out_z     (rsp_if.out_z),
   .rsp_cal_valid (rsp_if.cal_valid),
   .rsp_last      (rsp_if.last)
);

`default_nettype wire
